// ===== design/gwd_pkg.sv =====
package gwd_pkg;

   // field and datapath widths
   localparam int SAMPLE_W   = 16;
   localparam int TWICE_W    = 18;
   localparam int TRIG_W     = 17;
   localparam int OUT_W      = 48;
   localparam int REC_W      = 46;
   localparam int VAL_W      = 48;
   localparam int PIECE_W    = 24;
   localparam int COEF_W     = 18;
   localparam int PROD_W     = PIECE_W + 1 + COEF_W;
   localparam int ACC_W      = 68;
   localparam int FRAC_W     = 16;
   localparam int Q_W        = ACC_W - FRAC_W;
   localparam int SUM_W      = Q_W + 2;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // sequencer lengths
   localparam int STEP_W       = 4;
   localparam int SAMPLE_STEPS = 7;
   localparam int ROT_STEPS    = 14;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_W - 1);

   typedef struct packed {
      logic signed [TWICE_W-1:0] twice_cosine;
      logic signed [TRIG_W-1:0]  bin_cosine;
      logic signed [TRIG_W-1:0]  bin_sine;
      logic signed [TRIG_W-1:0]  rotate_cosine;
      logic signed [TRIG_W-1:0]  rotate_sine;
   } cfg_type;

   typedef enum logic [2:0] {
      VAL_PREV1,
      VAL_PREV2,
      VAL_A,
      VAL_B,
      VAL_INDEX
   } val_sel_type;

   typedef enum logic [2:0] {
      COEF_TWICE_COS,
      COEF_BIN_COS,
      COEF_BIN_SIN,
      COEF_ROT_COS,
      COEF_ROT_SIN,
      COEF_NEG_ROT_SIN,
      COEF_SAMPLE
   } coef_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_INIT,
      ACC_ADD0,
      ACC_ADD16,
      ACC_ADD24
   } acc_op_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_WEIGHTED,
      WR_PLAIN,
      WR_A,
      WR_B,
      WR_REAL,
      WR_IMAG
   } wr_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SAMPLE,
      ST_ROTATE,
      ST_PUBLISH
   } ctrl_state_type;

   typedef struct packed {
      logic         capture;
      logic         pair;      // 0 plain recurrence, 1 weighted
      logic         hi;        // upper piece of the operand
      val_sel_type  val_sel;
      coef_sel_type coef_sel;
      acc_op_type   acc_op;
      wr_op_type    wr_op;
      logic         publish;
      logic         clear;
   } dp_cmd_type;

   typedef struct packed {
      logic last;
   } dp_status_type;

   localparam dp_cmd_type CMD_NOP = '{
      capture:  1'b0,
      pair:     1'b0,
      hi:       1'b0,
      val_sel:  VAL_PREV1,
      coef_sel: COEF_TWICE_COS,
      acc_op:   ACC_HOLD,
      wr_op:    WR_NONE,
      publish:  1'b0,
      clear:    1'b0
   };

   // per-sample micro-program; the accumulator consumes the product issued a step earlier
   function automatic dp_cmd_type sample_cmd(input logic [STEP_W-1:0] step);
      dp_cmd_type cmd;
      cmd = CMD_NOP;
      unique case (step)
         STEP_W'(0): begin
            cmd.capture  = 1'b1;
            cmd.pair     = 1'b1;
            cmd.coef_sel = COEF_TWICE_COS;
         end
         STEP_W'(1): begin
            cmd.pair     = 1'b1;
            cmd.hi       = 1'b1;
            cmd.coef_sel = COEF_TWICE_COS;
            cmd.acc_op   = ACC_INIT;
         end
         STEP_W'(2): begin
            cmd.val_sel  = VAL_INDEX;
            cmd.coef_sel = COEF_SAMPLE;
            cmd.acc_op   = ACC_ADD24;
         end
         STEP_W'(3): begin
            cmd.coef_sel = COEF_TWICE_COS;
            cmd.acc_op   = ACC_ADD16;
         end
         STEP_W'(4): begin
            cmd.hi       = 1'b1;
            cmd.coef_sel = COEF_TWICE_COS;
            cmd.acc_op   = ACC_INIT;
            cmd.wr_op    = WR_WEIGHTED;
         end
         STEP_W'(5): begin
            cmd.acc_op   = ACC_ADD24;
         end
         STEP_W'(6): begin
            cmd.wr_op    = WR_PLAIN;
         end
         default: cmd = CMD_NOP;
      endcase
      return cmd;
   endfunction

   // frame-end rotation of one recurrence pair
   function automatic dp_cmd_type rot_cmd(input logic [STEP_W-1:0] step, input logic pair);
      dp_cmd_type cmd;
      cmd      = CMD_NOP;
      cmd.pair = pair;
      unique case (step)
         STEP_W'(0): begin
            cmd.val_sel = VAL_PREV2;  cmd.coef_sel = COEF_BIN_COS;
         end
         STEP_W'(1): begin
            cmd.val_sel = VAL_PREV2;  cmd.coef_sel = COEF_BIN_COS;  cmd.hi = 1'b1;
            cmd.acc_op  = ACC_INIT;
         end
         STEP_W'(2): begin
            cmd.val_sel = VAL_PREV2;  cmd.coef_sel = COEF_BIN_SIN;
            cmd.acc_op  = ACC_ADD24;
         end
         STEP_W'(3): begin
            cmd.val_sel = VAL_PREV2;  cmd.coef_sel = COEF_BIN_SIN;  cmd.hi = 1'b1;
            cmd.acc_op  = ACC_INIT;   cmd.wr_op = WR_A;
         end
         STEP_W'(4): begin
            cmd.val_sel = VAL_A;      cmd.coef_sel = COEF_ROT_COS;
            cmd.acc_op  = ACC_ADD24;
         end
         STEP_W'(5): begin
            cmd.val_sel = VAL_A;      cmd.coef_sel = COEF_ROT_COS;  cmd.hi = 1'b1;
            cmd.acc_op  = ACC_INIT;   cmd.wr_op = WR_B;
         end
         STEP_W'(6): begin
            cmd.val_sel = VAL_B;      cmd.coef_sel = COEF_ROT_SIN;
            cmd.acc_op  = ACC_ADD24;
         end
         STEP_W'(7): begin
            cmd.val_sel = VAL_B;      cmd.coef_sel = COEF_ROT_SIN;  cmd.hi = 1'b1;
            cmd.acc_op  = ACC_ADD0;
         end
         STEP_W'(8): begin
            cmd.val_sel = VAL_A;      cmd.coef_sel = COEF_NEG_ROT_SIN;
            cmd.acc_op  = ACC_ADD24;
         end
         STEP_W'(9): begin
            cmd.val_sel = VAL_A;      cmd.coef_sel = COEF_NEG_ROT_SIN;  cmd.hi = 1'b1;
            cmd.acc_op  = ACC_INIT;   cmd.wr_op = WR_REAL;
         end
         STEP_W'(10): begin
            cmd.val_sel = VAL_B;      cmd.coef_sel = COEF_ROT_COS;
            cmd.acc_op  = ACC_ADD24;
         end
         STEP_W'(11): begin
            cmd.val_sel = VAL_B;      cmd.coef_sel = COEF_ROT_COS;  cmd.hi = 1'b1;
            cmd.acc_op  = ACC_ADD0;
         end
         STEP_W'(12): begin
            cmd.acc_op  = ACC_ADD24;
         end
         STEP_W'(13): begin
            cmd.wr_op   = WR_IMAG;
         end
         default: cmd = CMD_NOP;
      endcase
      return cmd;
   endfunction

endpackage

// ===== design/gwd_dp.sv =====
module gwd_dp #(
   parameter int MAX_FRAME = 4096
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  gwd_pkg::cfg_type                       cfg,
   input  gwd_pkg::dp_cmd_type                    cmd,
   output gwd_pkg::dp_status_type                 status,
   input  logic signed [gwd_pkg::SAMPLE_W-1:0]    req_sample,
   input  logic                                   req_last_sample,
   output logic signed [gwd_pkg::OUT_W-1:0]       rsp_spec_real,
   output logic signed [gwd_pkg::OUT_W-1:0]       rsp_spec_imag,
   output logic signed [gwd_pkg::OUT_W-1:0]       rsp_deriv_real,
   output logic signed [gwd_pkg::OUT_W-1:0]       rsp_deriv_imag
);
   import gwd_pkg::*;

   localparam int IDX_W = $clog2(MAX_FRAME);

   function automatic logic signed [REC_W-1:0] sat_rec(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-REC_W:0] top;
      top = v[SUM_W-1:REC_W-1];
      if (&top || ~|top) begin
         return v[REC_W-1:0];
      end else if (v[SUM_W-1]) begin
         return {1'b1, {(REC_W-1){1'b0}}};
      end else begin
         return {1'b0, {(REC_W-1){1'b1}}};
      end
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [Q_W-1:0] v);
      logic [Q_W-OUT_W:0] top;
      top = v[Q_W-1:OUT_W-1];
      if (&top || ~|top) begin
         return v[OUT_W-1:0];
      end else if (v[Q_W-1]) begin
         return {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         return {1'b0, {(OUT_W-1){1'b1}}};
      end
   endfunction

   // recurrence state and sample index
   logic signed [REC_W-1:0]    plain1_ff, plain1_in, plain2_ff, plain2_in;
   logic signed [REC_W-1:0]    weight1_ff, weight1_in, weight2_ff, weight2_in;
   logic [IDX_W-1:0]           idx_ff, idx_in, idx_next;
   logic                       last_ff, last_in;
   // working registers
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in, prod_ext;
   logic signed [VAL_W-1:0]    a_ff, a_in, b_ff, b_in;
   logic signed [OUT_W-1:0]    sr_ff, sr_in, si_ff, si_in, dr_ff, dr_in, di_ff, di_in;
   logic signed [OUT_W-1:0]    osr_ff, osr_in, osi_ff, osi_in, odr_ff, odr_in, odi_ff, odi_in;
   // combinational
   logic signed [VAL_W-1:0]    mul_val;
   logic signed [PIECE_W:0]    mul_piece;
   logic signed [COEF_W-1:0]   mul_coef;
   logic signed [Q_W-1:0]      acc_q;
   logic signed [REC_W-1:0]    prev1_sel, prev2_sel;
   logic signed [SUM_W-1:0]    plain_sum, weight_sum, a_sum;
   logic signed [OUT_W-1:0]    q_sat;

   assign prev1_sel = cmd.pair ? weight1_ff : plain1_ff;
   assign prev2_sel = cmd.pair ? weight2_ff : plain2_ff;

   // shared 25x18 multiplier, one partial product a cycle
   always_comb begin
      unique case (cmd.val_sel)
         VAL_PREV1: mul_val = VAL_W'(prev1_sel);
         VAL_PREV2: mul_val = VAL_W'(prev2_sel);
         VAL_A:     mul_val = a_ff;
         VAL_B:     mul_val = b_ff;
         VAL_INDEX: mul_val = VAL_W'(idx_ff);
         default:   mul_val = '0;
      endcase
      unique case (cmd.coef_sel)
         COEF_TWICE_COS:   mul_coef = COEF_W'(cfg.twice_cosine);
         COEF_BIN_COS:     mul_coef = COEF_W'(cfg.bin_cosine);
         COEF_BIN_SIN:     mul_coef = COEF_W'(cfg.bin_sine);
         COEF_ROT_COS:     mul_coef = COEF_W'(cfg.rotate_cosine);
         COEF_ROT_SIN:     mul_coef = COEF_W'(cfg.rotate_sine);
         COEF_NEG_ROT_SIN: mul_coef = -COEF_W'(cfg.rotate_sine);
         COEF_SAMPLE:      mul_coef = COEF_W'(x_ff);
         default:          mul_coef = '0;
      endcase
      if (cmd.hi) begin
         mul_piece = {mul_val[VAL_W-1], mul_val[VAL_W-1:PIECE_W]};
      end else begin
         mul_piece = {1'b0, mul_val[PIECE_W-1:0]};
      end
      prod_in = mul_piece * mul_coef;
   end

   // accumulator
   assign prod_ext = ACC_W'(prod_ff);
   assign acc_q    = acc_ff[ACC_W-1:FRAC_W];
   always_comb begin
      unique case (cmd.acc_op)
         ACC_INIT:  acc_in = ROUND_HALF + prod_ext;
         ACC_ADD0:  acc_in = acc_ff + prod_ext;
         ACC_ADD16: acc_in = acc_ff + (prod_ext <<< FRAC_W);
         ACC_ADD24: acc_in = acc_ff + (prod_ext <<< PIECE_W);
         default:   acc_in = acc_ff;
      endcase
   end

   assign plain_sum  = SUM_W'(x_ff) + SUM_W'(acc_q) - SUM_W'(plain2_ff);
   assign weight_sum = SUM_W'(acc_q) - SUM_W'(weight2_ff);
   assign a_sum      = SUM_W'(prev1_sel) - SUM_W'(acc_q);
   assign q_sat      = sat_out(acc_q);
   assign idx_next   = (idx_ff == IDX_W'(MAX_FRAME - 1)) ? '0 : idx_ff + 1'b1;

   always_comb begin
      plain1_in  = plain1_ff;
      plain2_in  = plain2_ff;
      weight1_in = weight1_ff;
      weight2_in = weight2_ff;
      idx_in     = idx_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      sr_in      = sr_ff;
      si_in      = si_ff;
      dr_in      = dr_ff;
      di_in      = di_ff;
      x_in       = cmd.capture ? req_sample : x_ff;
      last_in    = cmd.capture ? req_last_sample : last_ff;
      unique case (cmd.wr_op)
         WR_PLAIN: begin
            plain2_in = plain1_ff;
            plain1_in = sat_rec(plain_sum);
         end
         WR_WEIGHTED: begin
            weight2_in = weight1_ff;
            weight1_in = sat_rec(weight_sum);
            idx_in     = idx_next;
         end
         WR_A: a_in = a_sum[VAL_W-1:0];
         WR_B: b_in = acc_q[VAL_W-1:0];
         WR_REAL: begin
            if (cmd.pair) begin
               dr_in = q_sat;
            end else begin
               sr_in = q_sat;
            end
         end
         WR_IMAG: begin
            if (cmd.pair) begin
               di_in = q_sat;
            end else begin
               si_in = q_sat;
            end
         end
         default: ;
      endcase
      if (cmd.clear) begin
         plain1_in  = '0;
         plain2_in  = '0;
         weight1_in = '0;
         weight2_in = '0;
         idx_in     = '0;
      end
      osr_in = cmd.publish ? sr_ff : osr_ff;
      osi_in = cmd.publish ? si_ff : osi_ff;
      odr_in = cmd.publish ? dr_ff : odr_ff;
      odi_in = cmd.publish ? di_ff : odi_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plain1_ff  <= '0;
         plain2_ff  <= '0;
         weight1_ff <= '0;
         weight2_ff <= '0;
         idx_ff     <= '0;
         last_ff    <= 1'b0;
      end else begin
         plain1_ff  <= plain1_in;
         plain2_ff  <= plain2_in;
         weight1_ff <= weight1_in;
         weight2_ff <= weight2_in;
         idx_ff     <= idx_in;
         last_ff    <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      sr_ff   <= sr_in;
      si_ff   <= si_in;
      dr_ff   <= dr_in;
      di_ff   <= di_in;
      osr_ff  <= osr_in;
      osi_ff  <= osi_in;
      odr_ff  <= odr_in;
      odi_ff  <= odi_in;
   end

   assign status.last    = last_ff;
   assign rsp_spec_real  = osr_ff;
   assign rsp_spec_imag  = osi_ff;
   assign rsp_deriv_real = odr_ff;
   assign rsp_deriv_imag = odi_ff;

endmodule

// ===== design/gwd_ctrl.sv =====
module gwd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  gwd_pkg::dp_status_type status,
   output gwd_pkg::dp_cmd_type    cmd
);
   import gwd_pkg::*;

   ctrl_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              pair_ff, pair_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              publish_ok;

   assign publish_ok = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      pair_in  = pair_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SAMPLE;
               step_in  = STEP_W'(1);
            end
         end
         ST_SAMPLE: begin
            if (step_ff == STEP_W'(SAMPLE_STEPS - 1)) begin
               step_in  = '0;
               pair_in  = 1'b0;
               state_in = status.last ? ST_ROTATE : ST_IDLE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_ROTATE: begin
            if (step_ff == STEP_W'(ROT_STEPS - 1)) begin
               step_in = '0;
               if (pair_ff) begin
                  state_in = ST_PUBLISH;
               end else begin
                  pair_in = 1'b1;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_PUBLISH: begin
            if (publish_ok) begin
               state_in = ST_IDLE;
               pair_in  = 1'b0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd          = CMD_NOP;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = reset;
            if (req_valid && !reset) begin
               cmd = sample_cmd('0);
            end
         end
         ST_SAMPLE: cmd = sample_cmd(step_ff);
         ST_ROTATE: cmd = rot_cmd(step_ff, pair_ff);
         ST_PUBLISH: begin
            if (publish_ok) begin
               cmd.publish  = 1'b1;
               cmd.clear    = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         pair_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         pair_ff      <= pair_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_rsp_from_publish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_PUBLISH))
      else $error("result beat raised outside publish");

   a_accept_starts_sample: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=> (state_ff == ST_SAMPLE && step_ff == STEP_W'(1)))
      else $error("accepted beat did not start the sample sequence");

   a_no_rotate_without_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SAMPLE && step_ff == STEP_W'(SAMPLE_STEPS - 1) && !status.last)
      |=> (state_ff == ST_IDLE))
      else $error("rotation started on a sample not marked last");

   a_rotate_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROTATE) |-> (step_ff <= STEP_W'(ROT_STEPS - 1)))
      else $error("rotation step out of range");

   a_publish_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUBLISH && rsp_valid_ff && rsp_stall)
      |=> (state_ff == ST_PUBLISH && rsp_valid_ff))
      else $error("publish overran a waiting result beat");
`endif

endmodule

// ===== design/goertzel_with_derivative.sv =====
// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_stall   req_sample (s16), req_last_sample
// rsp_      out        rsp_valid / rsp_stall   rsp_spec_real/imag, rsp_deriv_real/imag (s48)
// csr_      in         APB, pready tied high   five coefficient registers at 4*i
//
// A sample beat holds the block for its whole sample sequence: one 25x18 multiplier
// is shared, and each recurrence needs two partial products of 2*cos against its 46-bit
// state; the weighted one also needs sample*index. A beat marked last adds two rotation
// passes and a publish step, more if the output register still holds a beat not yet taken.
// A finished result waits in staging registers, so the output register parts the two sides.
// Synchronous reset clears recurrences, index, control and config (bin and rotate cos terms to 65535).
module goertzel_with_derivative #(
   parameter int MAX_FRAME = 4096
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // sample channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [gwd_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic                                    req_last_sample,
   // result channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [gwd_pkg::OUT_W-1:0]        rsp_spec_real,
   output logic signed [gwd_pkg::OUT_W-1:0]        rsp_spec_imag,
   output logic signed [gwd_pkg::OUT_W-1:0]        rsp_deriv_real,
   output logic signed [gwd_pkg::OUT_W-1:0]        rsp_deriv_imag,
   // register port
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [gwd_pkg::CSR_ADDR_W-1:0]          csr_paddr,
   input  logic [gwd_pkg::CSR_DATA_W-1:0]          csr_pwdata,
   output logic [gwd_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                    csr_pready
);
   import gwd_pkg::*;

   // register map, word index
   localparam logic [2:0] REG_TWICE_COS = 3'd0;
   localparam logic [2:0] REG_BIN_COS   = 3'd1;
   localparam logic [2:0] REG_BIN_SIN   = 3'd2;
   localparam logic [2:0] REG_ROT_COS   = 3'd3;
   localparam logic [2:0] REG_ROT_SIN   = 3'd4;

   localparam logic signed [TRIG_W-1:0] COS_RESET = TRIG_W'(65535);

   cfg_type       cfg_ff, cfg_in;
   logic [2:0]    reg_index;
   logic          csr_write;
   dp_cmd_type    cmd;
   dp_status_type status;

   assign reg_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // register writes: low bits of the write data, unknown indexes dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_index)
            REG_TWICE_COS: cfg_in.twice_cosine  = csr_pwdata[TWICE_W-1:0];
            REG_BIN_COS:   cfg_in.bin_cosine    = csr_pwdata[TRIG_W-1:0];
            REG_BIN_SIN:   cfg_in.bin_sine      = csr_pwdata[TRIG_W-1:0];
            REG_ROT_COS:   cfg_in.rotate_cosine = csr_pwdata[TRIG_W-1:0];
            REG_ROT_SIN:   cfg_in.rotate_sine   = csr_pwdata[TRIG_W-1:0];
            default: ;
         endcase
      end
   end

   // read back sign-extended
   always_comb begin
      unique case (reg_index)
         REG_TWICE_COS: csr_prdata = CSR_DATA_W'(cfg_ff.twice_cosine);
         REG_BIN_COS:   csr_prdata = CSR_DATA_W'(cfg_ff.bin_cosine);
         REG_BIN_SIN:   csr_prdata = CSR_DATA_W'(cfg_ff.bin_sine);
         REG_ROT_COS:   csr_prdata = CSR_DATA_W'(cfg_ff.rotate_cosine);
         REG_ROT_SIN:   csr_prdata = CSR_DATA_W'(cfg_ff.rotate_sine);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.twice_cosine  <= '0;
         cfg_ff.bin_cosine    <= COS_RESET;
         cfg_ff.bin_sine      <= '0;
         cfg_ff.rotate_cosine <= COS_RESET;
         cfg_ff.rotate_sine   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer: sample steps, then on a last sample two rotation passes, then publish and clear
   gwd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // recurrences, shared multiplier, accumulator and result registers
   gwd_dp #(
      .MAX_FRAME (MAX_FRAME)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd             (cmd),
      .status          (status),
      .req_sample      (req_sample),
      .req_last_sample (req_last_sample),
      .rsp_spec_real   (rsp_spec_real),
      .rsp_spec_imag   (rsp_spec_imag),
      .rsp_deriv_real  (rsp_deriv_real),
      .rsp_deriv_imag  (rsp_deriv_imag)
   );

endmodule
